### rtl/core/pdoq_pkg.sv
// pdoq_pkg: types, codes and helpers shared by the sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package pdoq_pkg;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_COUNT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_SCAN,
		S_CMP
	} state_t;

	// sort key, most significant field first so a plain compare orders it
	typedef struct packed {
		logic [2:0]  prio;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	localparam logic [2:0] CAT_BOSS        = 3'd0;
	localparam logic [2:0] CAT_SUBORDINATE = 3'd1;
	localparam logic [2:0] CAT_PEER        = 3'd2;
	localparam logic [2:0] CAT_IMPORTANT   = 3'd3;

	function automatic logic [2:0] prio_of(input logic [2:0] cat);
		logic [2:0] p;
		unique case (cat)
			CAT_BOSS:        p = 3'd5;
			CAT_SUBORDINATE: p = 3'd4;
			CAT_PEER:        p = 3'd3;
			CAT_IMPORTANT:   p = 3'd2;
			default:         p = 3'd1;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/priority_date_ordered_queue.sv
// priority_date_ordered_queue: sorted bounded queue, top level and sequencer
// depends on pdoq_pkg, pdoq_rank, pdoq_mem
`timescale 1ns / 1ps

// Holds up to DEPTH entries in a ring-addressed single-port memory, kept in
// service order: higher priority, then newer date, then earlier arrival. A
// word is taken when start is high and busy is low; its result shows on the
// result ports for one cycle with done high and cannot be held off. Count
// requests, pushes into a full queue and pops or peeks on an empty queue
// answer in the cycle after acceptance without raising busy. A pop or peek
// answers after one memory read of the head entry, through S_HEAD. A push walks back
// from the tail with one read and one write of the memory port per step and
// one shared key compare, alternating S_SCAN and S_CMP, and answers when a
// compare stops it or when it reaches the head. Pops move only the head
// pointer. No clearing pass is needed.
module priority_date_ordered_queue
	import pdoq_pkg::*;
#(
	parameter int DEPTH    = 128,
	parameter int TAG_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [2:0]          category,
	input  logic [13:0]         year,
	input  logic [3:0]          month,
	input  logic [4:0]          day,
	input  logic [TAG_BITS-1:0] tag,
	output logic                done,
	output logic [1:0]          status,
	output logic [2:0]          priority_res,
	output logic [13:0]         out_year,
	output logic [3:0]          out_month,
	output logic [4:0]          out_day,
	output logic [TAG_BITS-1:0] out_tag,
	output logic [7:0]          count
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int EW = KEY_W + TAG_BITS;

	state_t            state_q, state_d;
	logic [FW-1:0]     fill_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     p_q;
	logic [EW-1:0]     new_q;
	logic              pop_q;
	logic              done_q;
	status_t           status_q;
	logic [EW-1:0]     res_q;

	logic [AW-1:0]     log_idx;
	logic [AW:0]       phys_sum;
	logic [AW-1:0]     phys;
	logic              mem_en, mem_we;
	logic [EW-1:0]     mem_wdata, mem_rdata;
	logic              below;
	logic              full, empty;
	key_t              res_key;

	assign full  = (fill_q == FW'(DEPTH));
	assign empty = (fill_q == '0);

	// logical slot to ring address
	always_comb begin
		unique case (state_q)
			S_SCAN:  log_idx = (p_q != '0) ? p_q - 1'b1 : p_q;
			S_CMP:   log_idx = p_q;
			default: log_idx = '0;
		endcase
		phys_sum = {1'b0, head_q} + {1'b0, log_idx};
		if (phys_sum >= (AW+1)'(DEPTH)) begin
			phys = AW'(phys_sum - (AW+1)'(DEPTH));
		end else begin
			phys = AW'(phys_sum);
		end
	end

	pdoq_rank u_rank (
		.held     (key_t'(mem_rdata[EW-1:TAG_BITS])),
		.incoming (key_t'(new_q[EW-1:TAG_BITS])),
		.below    (below)
	);

	pdoq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (phys),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = new_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (mode)
						MODE_PUSH: begin
							if (!full) begin
								state_d = S_SCAN;
							end
						end
						MODE_POP, MODE_PEEK: begin
							if (!empty) begin
								mem_en  = 1'b1;
								state_d = S_HEAD;
							end
						end
						MODE_COUNT: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_HEAD: begin
				state_d = S_IDLE;
			end
			S_SCAN: begin
				mem_en = 1'b1;
				if (p_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
				if (below) begin
					mem_wdata = mem_rdata;
					state_d   = S_SCAN;
				end else begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			head_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if ((mode == MODE_PUSH && full) || mode == MODE_COUNT ||
						    ((mode == MODE_POP || mode == MODE_PEEK) && empty)) begin
							done_q <= 1'b1;
						end
					end
				end
				S_HEAD: begin
					done_q <= 1'b1;
					if (pop_q) begin
						fill_q <= fill_q - 1'b1;
						head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (p_q == '0) begin
						done_q <= 1'b1;
						fill_q <= fill_q + 1'b1;
					end
				end
				S_CMP: begin
					if (!below) begin
						done_q <= 1'b1;
						fill_q <= fill_q + 1'b1;
					end
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					pop_q    <= (mode == MODE_POP);
					new_q    <= {prio_of(category), year, month, day, tag};
					p_q      <= AW'(fill_q);
					res_q    <= '0;
					status_q <= ST_OK;
					if (mode == MODE_PUSH && full) begin
						status_q <= ST_FULL;
					end else if ((mode == MODE_POP || mode == MODE_PEEK) && empty) begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_HEAD: begin
				res_q    <= mem_rdata;
				status_q <= ST_OK;
			end
			S_SCAN: begin
				res_q    <= '0;
				status_q <= ST_OK;
			end
			S_CMP: begin
				if (below) begin
					p_q <= p_q - 1'b1;
				end
				res_q    <= '0;
				status_q <= ST_OK;
			end
		endcase
	end

	assign res_key      = key_t'(res_q[EW-1:TAG_BITS]);
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign priority_res = res_key.prio;
	assign out_year     = res_key.year;
	assign out_month    = res_key.month;
	assign out_day      = res_key.day;
	assign out_tag      = res_q[TAG_BITS-1:0];
	assign count        = 8'(fill_q);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count above depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while sequencer busy");

	a_cmp_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_SCAN)
		else $error("compare step without a preceding read");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_EMPTY |-> fill_q == '0)
		else $error("empty reported with entries held");

	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_FULL |-> fill_q == FW'(DEPTH))
		else $error("full reported with room left");
`endif

endmodule

### rtl/core/pdoq_rank.sv
// pdoq_rank: shared ordering compare used by the insertion scan
// depends on pdoq_pkg
`timescale 1ns / 1ps

module pdoq_rank
	import pdoq_pkg::*;
(
	input  key_t held,
	input  key_t incoming,
	output logic below
);

	// held entry is served after the incoming one
	assign below = (held < incoming);

endmodule

### rtl/core/pdoq_mem.sv
// pdoq_mem: single-port entry store with registered read data
// no dependencies
`timescale 1ns / 1ps

module pdoq_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 42
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for priority_date_ordered_queue, with a sorted queue
// model that predicts every word's answer, directed corner words, then random phases
// depends on pdoq_pkg and the priority_date_ordered_queue rtl
`timescale 1ns / 1ps

localparam int QUEUE_DEPTH = 128;

typedef struct {
	logic [2:0]  prio;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [15:0] tag;
} held_entry_t;

typedef struct {
	pdoq_pkg::status_t status;
	logic [2:0]        prio;
	logic [13:0]       year;
	logic [3:0]        month;
	logic [4:0]        day;
	logic [15:0]       tag;
	logic [7:0]        count;
} answer_t;

class sorted_queue_model;
	held_entry_t held[$];
	answer_t     pending_answers[$];
	int errors, pushes, drops, pops, peeks, counts, empties, peak_fill;

	function logic [2:0] rank_of(logic [2:0] cat);
		case (cat)
			pdoq_pkg::CAT_BOSS:        return 3'd5;
			pdoq_pkg::CAT_SUBORDINATE: return 3'd4;
			pdoq_pkg::CAT_PEER:        return 3'd3;
			pdoq_pkg::CAT_IMPORTANT:   return 3'd2;
			default:                   return 3'd1;
		endcase
	endfunction

	function void accept_word(pdoq_pkg::mode_t m, logic [2:0] cat, logic [13:0] y,
			logic [3:0] mo, logic [4:0] d, logic [15:0] t);
		held_entry_t n;
		answer_t a;
		int pos;
		a.status = pdoq_pkg::ST_OK;
		a.prio = '0;
		a.year = '0;
		a.month = '0;
		a.day = '0;
		a.tag = '0;
		case (m)
			pdoq_pkg::MODE_PUSH: begin
				pushes++;
				if (held.size() >= QUEUE_DEPTH) begin
					a.status = pdoq_pkg::ST_FULL;
					drops++;
				end else begin
					n = '{rank_of(cat), y, mo, d, t};
					pos = 0;
					// equal keys stay behind earlier arrivals
					while (pos < held.size() && {held[pos].prio, held[pos].year, held[pos].month,
							held[pos].day} >= {n.prio, n.year, n.month, n.day})
						pos++;
					held.insert(pos, n);
				end
			end
			pdoq_pkg::MODE_POP, pdoq_pkg::MODE_PEEK: begin
				if (m == pdoq_pkg::MODE_POP) pops++;
				else peeks++;
				if (held.size() == 0) begin
					a.status = pdoq_pkg::ST_EMPTY;
					empties++;
				end else begin
					a.prio = held[0].prio;
					a.year = held[0].year;
					a.month = held[0].month;
					a.day = held[0].day;
					a.tag = held[0].tag;
					if (m == pdoq_pkg::MODE_POP) held.delete(0);
				end
			end
			default: counts++;
		endcase
		a.count = 8'(held.size());
		if (held.size() > peak_fill) peak_fill = held.size();
		pending_answers.push_back(a);
	endfunction

	function void compare_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endfunction

	function void check_word(logic [1:0] st, logic [2:0] pr, logic [13:0] y, logic [3:0] mo,
			logic [4:0] d, logic [15:0] t, logic [7:0] cnt);
		answer_t a;
		if (pending_answers.size() == 0) begin
			$display("%0t: unexpected word, expected none, actual status %0d count %0d",
				$time, st, cnt);
			errors++;
			return;
		end
		a = pending_answers.pop_front();
		compare_field("status", int'(a.status), int'(st));
		compare_field("priority_res", int'(a.prio), int'(pr));
		compare_field("out_year", int'(a.year), int'(y));
		compare_field("out_month", int'(a.month), int'(mo));
		compare_field("out_day", int'(a.day), int'(d));
		compare_field("out_tag", int'(a.tag), int'(t));
		compare_field("count", int'(a.count), int'(cnt));
	endfunction
endclass

module testbench;
	import pdoq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [2:0]  category;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [15:0] tag;
	logic        done;
	logic [1:0]  status;
	logic [2:0]  priority_res;
	logic [13:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [15:0] out_tag;
	logic [7:0]  count;

	sorted_queue_model model = new();
	int burst_left = 0;
	int words_sent = 0;

	priority_date_ordered_queue #(
		.DEPTH    (QUEUE_DEPTH),
		.TAG_BITS (16)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.category     (category),
		.year         (year),
		.month        (month),
		.day          (day),
		.tag          (tag),
		.done         (done),
		.status       (status),
		.priority_res (priority_res),
		.out_year     (out_year),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_tag      (out_tag),
		.count        (count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			model.check_word(status, priority_res, out_year, out_month, out_day, out_tag, count);
	end

	task automatic send_word(mode_t m, logic [2:0] cat, logic [13:0] y, logic [3:0] mo,
			logic [4:0] d, logic [15:0] t);
		int gap;
		start <= 1'b1;
		mode <= m;
		category <= cat;
		year <= y;
		month <= mo;
		day <= d;
		tag <= t;
		do @(posedge clk); while (busy);
		model.accept_word(m, cat, y, mo, d, t);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
		end
	endtask

	// fields other than mode are ignored here, so they carry noise
	task automatic send_op(mode_t m);
		send_word(m, 3'($urandom), 14'($urandom), 4'($urandom), 5'($urandom), 16'($urandom));
	endtask

	task automatic push_random();
		logic [13:0] y;
		logic [3:0]  mo;
		logic [4:0]  d;
		case ($urandom_range(0, 3))
			0: begin
				y = 14'($urandom);
				mo = 4'($urandom);
				d = 5'($urandom);
			end
			1: begin
				// narrow dates so equal keys are common
				y = 14'd2020;
				mo = 4'($urandom_range(1, 2));
				d = 5'($urandom_range(1, 2));
			end
			default: begin
				y = 14'($urandom_range(1990, 2030));
				mo = 4'($urandom_range(1, 12));
				d = 5'($urandom_range(1, 31));
			end
		endcase
		send_word(MODE_PUSH, 3'($urandom_range(0, 7)), y, mo, d, 16'($urandom));
	endtask

	initial begin
		#30_000_000;
		$display("priority_date_ordered_queue test failed");
		$finish;
	end

	initial begin
		int pick;
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= MODE_COUNT;
		category <= '0;
		year <= '0;
		month <= '0;
		day <= '0;
		tag <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner words on an empty queue, then extremes, ties and every category code
		send_op(MODE_COUNT);
		send_op(MODE_POP);
		send_op(MODE_PEEK);
		send_word(MODE_PUSH, CAT_BOSS, 14'd9999, 4'd12, 5'd31, 16'hffff);
		send_word(MODE_PUSH, 3'd7, 14'd0, 4'd1, 5'd1, 16'h0000);
		send_word(MODE_PUSH, 3'd4, 14'h3fff, 4'hf, 5'h1f, 16'h8001);
		send_word(MODE_PUSH, 3'd5, 14'd0, 4'd0, 5'd0, 16'h7ffe);
		send_word(MODE_PUSH, 3'd6, 14'd2000, 4'd6, 5'd15, 16'h1234);
		send_word(MODE_PUSH, CAT_SUBORDINATE, 14'd2024, 4'd3, 5'd15, 16'h0001);
		send_word(MODE_PUSH, CAT_PEER, 14'd2024, 4'd3, 5'd15, 16'h0002);
		send_word(MODE_PUSH, CAT_IMPORTANT, 14'd2024, 4'd3, 5'd15, 16'h0003);
		send_word(MODE_PUSH, CAT_SUBORDINATE, 14'd2024, 4'd3, 5'd15, 16'h0004);
		send_word(MODE_PUSH, CAT_SUBORDINATE, 14'd2024, 4'd3, 5'd16, 16'h0005);
		send_word(MODE_PUSH, CAT_SUBORDINATE, 14'd2024, 4'd4, 5'd1, 16'h0006);
		send_word(MODE_PUSH, CAT_SUBORDINATE, 14'd2023, 4'd12, 5'd31, 16'h0007);
		send_op(MODE_PEEK);
		send_op(MODE_COUNT);
		repeat (6) send_op(MODE_POP);

		while (words_sent < 1750) begin
			case ($urandom_range(0, 5))
				0: begin
					while (model.held.size() < QUEUE_DEPTH) push_random();
					repeat ($urandom_range(1, 3)) push_random();
				end
				1: begin
					while (model.held.size() > 0) send_op(MODE_POP);
					repeat ($urandom_range(1, 3)) send_op($urandom_range(0, 1) ? MODE_POP : MODE_PEEK);
				end
				default: begin
					repeat ($urandom_range(20, 60)) begin
						pick = $urandom_range(0, 99);
						if (pick < 45) push_random();
						else if (pick < 75) send_op(MODE_POP);
						else if (pick < 90) send_op(MODE_PEEK);
						else send_op(MODE_COUNT);
					end
				end
			endcase
		end
		start <= 1'b0;

		for (int i = 0; i < 3000 && model.pending_answers.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (model.pending_answers.size() != 0) begin
			$display("%0t: missing words, expected %0d more, actual 0", $time,
				model.pending_answers.size());
			model.errors++;
		end

		$display("ran %0d words: %0d pushes (%0d dropped while full), %0d pops, %0d peeks, %0d counts",
			words_sent, model.pushes, model.drops, model.pops, model.peeks, model.counts);
		$display("%0d pops or peeks found the queue empty, peak fill %0d of %0d, %0d mismatches",
			model.empties, model.peak_fill, QUEUE_DEPTH, model.errors);
		if (model.errors == 0)
			$display("priority_date_ordered_queue test passed");
		else
			$display("priority_date_ordered_queue test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/pdoq_pkg.sv
rtl/core/pdoq_rank.sv
rtl/core/pdoq_mem.sv
rtl/core/priority_date_ordered_queue.sv
tb/sv/testbench.sv
